@@ rtl/pss_pkg.sv @@
// ----------------------------------------------------------------------------
// pss_pkg
// types and codes shared by the printf conversion specifier parser
// ----------------------------------------------------------------------------
package pss_pkg;

	localparam int ValW = 31;

	// parse phase codes
	localparam logic [3:0] PH_FLAGS   = 4'd0;
	localparam logic [3:0] PH_W_START = 4'd1;
	localparam logic [3:0] PH_W_STAR  = 4'd2;
	localparam logic [3:0] PH_W_DIG   = 4'd3;
	localparam logic [3:0] PH_P_START = 4'd4;
	localparam logic [3:0] PH_P_DOT   = 4'd5;
	localparam logic [3:0] PH_P_DIG   = 4'd6;
	localparam logic [3:0] PH_LEN     = 4'd7;
	localparam logic [3:0] PH_LEN_H   = 4'd8;
	localparam logic [3:0] PH_LEN_L   = 4'd9;
	localparam logic [3:0] PH_CONV    = 4'd10;
	localparam logic [3:0] PH_IDLE    = 4'd11;

	// flag bits
	localparam int F_ALT   = 0;
	localparam int F_SPACE = 1;
	localparam int F_PLUS  = 2;
	localparam int F_MINUS = 3;
	localparam int F_ZERO  = 4;

	// length modifiers
	localparam logic [2:0] LEN_NONE = 3'd0;
	localparam logic [2:0] LEN_H    = 3'd1;
	localparam logic [2:0] LEN_L    = 3'd2;
	localparam logic [2:0] LEN_BIGL = 3'd3;
	localparam logic [2:0] LEN_HH   = 3'd4;
	localparam logic [2:0] LEN_LL   = 3'd5;
	localparam logic [2:0] LEN_Z    = 3'd6;
	localparam logic [2:0] LEN_J    = 3'd7;

	// conversions
	localparam logic [3:0] CONV_NONE = 4'd0;
	localparam logic [3:0] CONV_S    = 4'd1;
	localparam logic [3:0] CONV_D    = 4'd2;
	localparam logic [3:0] CONV_C    = 4'd3;
	localparam logic [3:0] CONV_I    = 4'd4;
	localparam logic [3:0] CONV_O    = 4'd5;
	localparam logic [3:0] CONV_U    = 4'd6;
	localparam logic [3:0] CONV_X    = 4'd7;
	localparam logic [3:0] CONV_BIGX = 4'd8;
	localparam logic [3:0] CONV_P    = 4'd9;
	localparam logic [3:0] CONV_F    = 4'd10;
	localparam logic [3:0] CONV_BIGU = 4'd11;

	localparam logic [ValW-1:0] VAL_MAX = {ValW{1'b1}};

	typedef struct packed {
		logic [7:0]         in_char;
		logic signed [31:0] arg_value;
		logic               spec_start;
	} in_item_t;

	typedef struct packed {
		logic            char_consumed;
		logic            arg_taken;
		logic            spec_done;
		logic [4:0]      flags;
		logic [ValW-1:0] field_width;
		logic [ValW-1:0] precision;
		logic            precision_given;
		logic [2:0]      length_mod;
		logic [3:0]      conversion;
		logic            radix_prefix;
	} res_item_t;

endpackage

@@ rtl/printf_spec_parser_top.sv @@
// ----------------------------------------------------------------------------
// printf_spec_parser_top
// parses one printf conversion specifier a byte per transfer
// ----------------------------------------------------------------------------
// path: a byte is held in the input register, then in the result register
// throughput: one byte per cycle while char_stall is low; the held spec updates
//   in the single logic pass between the input register and the result register
// reset: arst_n clears the held spec to the flags phase and empties both
//   registers
// ----------------------------------------------------------------------------
module printf_spec_parser_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                char_valid,
	output logic                char_stall,
	input  pss_pkg::in_item_t   char_item,
	output logic                result_valid,
	input  logic                result_stall,
	output pss_pkg::res_item_t  result
);

	localparam int W = pss_pkg::ValW;

	logic                valid_s1;
	pss_pkg::in_item_t   item_s1;
	logic                res_valid_q;
	pss_pkg::res_item_t  res_q;

	logic [3:0]   phase_q;
	logic [4:0]   flags_q;
	logic [W-1:0] width_q;
	logic [W-1:0] prec_q;
	logic         pg_q;
	logic [2:0]   len_q;

	logic out_ready;
	logic adv;

	logic [3:0]   phase_d;
	logic [4:0]   flags_d;
	logic [W-1:0] width_d;
	logic [W-1:0] prec_d;
	logic         pg_d;
	logic [2:0]   len_d;
	pss_pkg::res_item_t res_d;

	logic         star_neg;
	logic [31:0]  star_abs;
	logic [W-1:0] star_mag;

	function automatic logic [W-1:0] mac10(input logic [W-1:0] v, input logic [3:0] d);
		logic [W+3:0] r;
		r = ({4'b0, v} << 3) + ({4'b0, v} << 1) + {{W{1'b0}}, d};
		return (r > {4'b0, pss_pkg::VAL_MAX}) ? pss_pkg::VAL_MAX : r[W-1:0];
	endfunction

	assign out_ready  = !res_valid_q || !result_stall;
	assign adv        = valid_s1 && out_ready;
	assign char_stall = valid_s1 && !out_ready;

	assign result_valid = res_valid_q;
	assign result       = res_q;

	// star magnitude, -2^31 saturates
	assign star_neg = item_s1.arg_value[31];
	assign star_abs = star_neg ? (~item_s1.arg_value + 32'd1) : item_s1.arg_value;
	assign star_mag = star_abs[31] ? pss_pkg::VAL_MAX : star_abs[W-1:0];

	always_comb begin
		logic [7:0] c;
		logic       isdig;
		logic       consumed;
		logic       taken;
		logic       done;
		logic [3:0] conv;
		logic [3:0] p;

		c = item_s1.in_char;
		p = phase_q;
		flags_d = flags_q;
		width_d = width_q;
		prec_d  = prec_q;
		pg_d    = pg_q;
		len_d   = len_q;
		consumed = 1'b0;
		taken    = 1'b0;
		done     = 1'b0;
		conv     = pss_pkg::CONV_NONE;

		if (item_s1.spec_start) begin
			p = pss_pkg::PH_FLAGS;
			flags_d = '0;
			width_d = '0;
			prec_d  = '0;
			pg_d    = 1'b0;
			len_d   = pss_pkg::LEN_NONE;
		end
		isdig = c inside {["0":"9"]};

		if (p == pss_pkg::PH_FLAGS) begin
			consumed = 1'b1;
			case (c)
				"#": flags_d[pss_pkg::F_ALT]   = 1'b1;
				" ": flags_d[pss_pkg::F_SPACE] = 1'b1;
				"+": flags_d[pss_pkg::F_PLUS]  = 1'b1;
				"-": flags_d[pss_pkg::F_MINUS] = 1'b1;
				"0": flags_d[pss_pkg::F_ZERO]  = 1'b1;
				default: begin
					consumed = 1'b0;
					p = pss_pkg::PH_W_START;
				end
			endcase
		end

		if (!consumed && (p == pss_pkg::PH_W_START || p == pss_pkg::PH_W_STAR
			|| p == pss_pkg::PH_W_DIG)) begin
			if (c == "*") begin
				taken = 1'b1;
				if (star_neg) flags_d[pss_pkg::F_MINUS] = 1'b1;
				width_d = star_mag;
				p = (p == pss_pkg::PH_W_START) ? pss_pkg::PH_W_STAR : pss_pkg::PH_P_START;
				consumed = 1'b1;
			end else if (isdig) begin
				width_d = (p == pss_pkg::PH_W_DIG) ? mac10(width_d, c[3:0])
					: {{(W-4){1'b0}}, c[3:0]};
				p = pss_pkg::PH_W_DIG;
				consumed = 1'b1;
			end else begin
				p = pss_pkg::PH_P_START;
			end
		end

		if (!consumed && p == pss_pkg::PH_P_START) begin
			if (c == ".") begin
				pg_d = 1'b1;
				prec_d = '0;
				p = pss_pkg::PH_P_DOT;
				consumed = 1'b1;
			end else begin
				p = pss_pkg::PH_LEN;
			end
		end

		if (!consumed && (p == pss_pkg::PH_P_DOT || p == pss_pkg::PH_P_DIG)) begin
			if (p == pss_pkg::PH_P_DOT && c == "*") begin
				taken = 1'b1;
				if (star_neg) begin
					prec_d = width_d;
					if (!flags_d[pss_pkg::F_ZERO]) pg_d = 1'b0;
				end else begin
					prec_d = star_mag;
				end
				p = pss_pkg::PH_LEN;
				consumed = 1'b1;
			end else if (isdig) begin
				prec_d = mac10(prec_d, c[3:0]);
				p = pss_pkg::PH_P_DIG;
				consumed = 1'b1;
			end else begin
				p = pss_pkg::PH_LEN;
			end
		end

		if (!consumed && p == pss_pkg::PH_LEN) begin
			consumed = 1'b1;
			p = pss_pkg::PH_CONV;
			case (c)
				"h": begin
					len_d = pss_pkg::LEN_H;
					p = pss_pkg::PH_LEN_H;
				end
				"l": begin
					len_d = pss_pkg::LEN_L;
					p = pss_pkg::PH_LEN_L;
				end
				"j": len_d = pss_pkg::LEN_J;
				"z": len_d = pss_pkg::LEN_Z;
				"L": len_d = pss_pkg::LEN_BIGL;
				default: begin
					len_d = pss_pkg::LEN_NONE;
					consumed = 1'b0;
				end
			endcase
		end

		if (!consumed && (p == pss_pkg::PH_LEN_H || p == pss_pkg::PH_LEN_L)) begin
			if (p == pss_pkg::PH_LEN_H && c == "h") begin
				len_d = pss_pkg::LEN_HH;
				consumed = 1'b1;
			end else if (p == pss_pkg::PH_LEN_L && c == "l") begin
				len_d = pss_pkg::LEN_LL;
				consumed = 1'b1;
			end
			p = pss_pkg::PH_CONV;
		end

		if (!consumed && p == pss_pkg::PH_CONV) begin
			case (c)
				"s", "S": conv = pss_pkg::CONV_S;
				"d": conv = pss_pkg::CONV_D;
				"D": begin
					conv = pss_pkg::CONV_D;
					len_d = pss_pkg::LEN_LL;
				end
				"c", "C": conv = pss_pkg::CONV_C;
				"p": begin
					conv = pss_pkg::CONV_P;
					flags_d[pss_pkg::F_ALT] = 1'b1;
				end
				"i": conv = pss_pkg::CONV_I;
				"o": conv = pss_pkg::CONV_O;
				"O": begin
					conv = pss_pkg::CONV_O;
					len_d = pss_pkg::LEN_LL;
				end
				"u": conv = pss_pkg::CONV_U;
				"U": conv = pss_pkg::CONV_BIGU;
				"x": conv = pss_pkg::CONV_X;
				"X": conv = pss_pkg::CONV_BIGX;
				"f", "F": conv = pss_pkg::CONV_F;
				default: conv = pss_pkg::CONV_NONE;
			endcase
			consumed = (conv != pss_pkg::CONV_NONE);
			done = 1'b1;
			p = pss_pkg::PH_IDLE;
		end

		phase_d = p;

		res_d.char_consumed   = consumed;
		res_d.arg_taken       = taken;
		res_d.spec_done       = done;
		res_d.flags           = flags_d;
		res_d.field_width     = width_d;
		res_d.precision       = prec_d;
		res_d.precision_given = pg_d;
		res_d.length_mod      = len_d;
		res_d.conversion      = conv;
		res_d.radix_prefix    = conv inside {pss_pkg::CONV_O, pss_pkg::CONV_X,
			pss_pkg::CONV_BIGX, pss_pkg::CONV_P};
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!char_stall) begin
			valid_s1 <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_valid && !char_stall) begin
			item_s1 <= char_item;
		end
	end

	// held spec
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= pss_pkg::PH_FLAGS;
			flags_q <= '0;
			width_q <= '0;
			prec_q  <= '0;
			pg_q    <= 1'b0;
			len_q   <= pss_pkg::LEN_NONE;
		end else if (adv) begin
			phase_q <= phase_d;
			flags_q <= flags_d;
			width_q <= width_d;
			prec_q  <= prec_d;
			pg_q    <= pg_d;
			len_q   <= len_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_ready) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_d;
		end
	end

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.spec_done) |-> (phase_q == pss_pkg::PH_IDLE))
		else $error("done result without idle phase");

	a_taken_consumed: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.arg_taken) |-> res_q.char_consumed)
		else $error("argument taken by an unconsumed byte");

	a_conv_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !res_q.spec_done)
		|-> (res_q.conversion == pss_pkg::CONV_NONE && !res_q.radix_prefix))
		else $error("conversion reported before done");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		char_stall |-> (valid_s1 && res_valid_q))
		else $error("stall with free input register");

	a_hold_state: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(phase_q) && $stable(width_q) && $stable(prec_q))
		else $error("held spec changed without a transfer");

endmodule
